// ===== rtl/core/rfps_pkg.sv =====
// Shared types and constants for the ring flow particle step block.
`default_nettype none
package rfps_pkg;

  localparam int NumRingsDef = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 31;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RING_COUNT  = 2'd0,
    CFG_HALF_WIDTH  = 2'd1,
    CFG_HALF_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic               action;
    logic [2:0]         ring_index;
    logic [30:0]        ring_inner_radius;
    logic [30:0]        ring_outer_radius;
    logic signed [31:0] ring_current;
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_vx;
    logic signed [31:0] particle_vy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic               ring_changed;
    logic [3:0]         ring_after;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/ring_flow_particle_step.sv =====
// Ring flow particle step: ring table, move, ring lookup, radial kick and wall bounce.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | rfps_pkg::in_item_t
//  out_    | output    | out_valid/out_stall | rfps_pkg::out_item_t
//  cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
//
// A load item squares both radii into the ring table. With n rings in use, a step item
// scans the n entries; when the ring changes it runs a 32-step square root and then,
// unless the particle lands on the origin, two products each with a 33-step divide, all
// on one shared 32x33 multiplier.
// Reset (rst_n low, synchronous) clears control state and config registers.
// in_stall is high while an item is in work; a finished item waits in the output
// register under out_stall while the next item is accepted.
`default_nettype none
module ring_flow_particle_step #(
  parameter int NUM_RINGS = rfps_pkg::NumRingsDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire rfps_pkg::in_item_t       in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output rfps_pkg::out_item_t           out_data,
  input  wire                           cfg_we,
  input  wire [rfps_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire [rfps_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int IdxW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int CntW = $clog2(NUM_RINGS + 1);
  localparam logic [CntW-1:0] NoRing = CntW'(NUM_RINGS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_LOAD   = 11'b00000000010,
    S_SQ     = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_DIFF   = 11'b00000010000,
    S_SQRT   = 11'b00000100000,
    S_KMUL   = 11'b00001000000,
    S_KDIV   = 11'b00010000000,
    S_KADD   = 11'b00100000000,
    S_BOUNCE = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] s);
    if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) sat35 = s[31:0];
    else if (s[34]) sat35 = 32'sh80000000;
    else sat35 = 32'sh7fffffff;
  endfunction

  function automatic logic signed [31:0] bounce(input logic signed [31:0] p,
                                                input logic signed [31:0] v,
                                                input logic [30:0] h);
    logic signed [32:0] ps;
    logic signed [32:0] hs;
    ps = {p[31], p};
    hs = {2'b00, h};
    if ((ps < -hs && v[31]) || (ps > hs && !v[31] && v != 32'sd0)) begin
      if (v == 32'sh80000000) bounce = 32'sh7fffffff;
      else bounce = -v;
    end else begin
      bounce = v;
    end
  endfunction

  // config
  logic [3:0]  ring_count_r;
  logic [30:0] half_width_r, half_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r  <= '0;
      half_width_r  <= '0;
      half_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rfps_pkg::CFG_RING_COUNT:  ring_count_r  <= cfg_wdata[3:0];
        rfps_pkg::CFG_HALF_WIDTH:  half_width_r  <= cfg_wdata;
        rfps_pkg::CFG_HALF_HEIGHT: half_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ring table, squared radii cached at load time
  logic [61:0] inner_sq_mem [NUM_RINGS];
  logic [61:0] outer_sq_mem [NUM_RINGS];
  logic [31:0] cur_mem      [NUM_RINGS];
  logic [61:0] inner_rd_r, outer_rd_r;
  logic [31:0] cur_rd_r;
  logic            rd_en, wr_in_en, wr_out_en;
  logic [IdxW-1:0] rd_addr, wr_addr;

  state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        is_load_r, is_load_nxt;
  logic [2:0]  ld_idx_r, ld_idx_nxt;
  logic [30:0] ld_ir_r, ld_ir_nxt, ld_or_r, ld_or_nxt;
  logic [31:0] ld_cur_r, ld_cur_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic [63:0] p_r, p_nxt, d2b_r, d2b_nxt, d2a_r, d2a_nxt;
  logic [CntW-1:0] scan_cnt_r, scan_cnt_nxt, rd_idx_r, rd_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [CntW-1:0] bef_r, bef_nxt, aft_r, aft_nxt;
  logic            fnd_b_r, fnd_b_nxt, fnd_a_r, fnd_a_nxt;
  logic signed [31:0] cur_b_r, cur_b_nxt, cur_a_r, cur_a_nxt;
  logic [32:0] dv_r, dv_nxt;
  logic [63:0] sq_n_r, sq_n_nxt;
  logic [31:0] root_r, root_nxt;
  logic [32:0] srem_r, srem_nxt;
  logic [32:0] drem_r, drem_nxt, dq_r, dq_nxt;
  logic        axis_r, axis_nxt;
  logic        out_valid_r, out_valid_nxt;
  rfps_pkg::out_item_t out_data_r, out_data_nxt;

  logic [CntW-1:0] used_n;
  logic [31:0]     mul_a;
  logic [32:0]     mul_b;
  logic [31:0]     sq_op;
  logic            hit_b, hit_a;
  logic signed [32:0] diff;
  logic [34:0]     srem_sh, trial;
  logic [33:0]     drem_sh;
  logic            qbit;
  logic signed [31:0] kp, kv;
  logic signed [33:0] kick;
  logic signed [34:0] ksum;

  assign used_n = (32'(ring_count_r) > NUM_RINGS) ? NoRing : CntW'(ring_count_r);

  always_ff @(posedge clk) begin
    if (wr_in_en)  inner_sq_mem[wr_addr] <= p_r[61:0];
    if (wr_out_en) begin
      outer_sq_mem[wr_addr] <= p_r[61:0];
      cur_mem[wr_addr]      <= ld_cur_r;
    end
    if (rd_en) begin
      inner_rd_r <= inner_sq_mem[rd_addr];
      outer_rd_r <= outer_sq_mem[rd_addr];
      cur_rd_r   <= cur_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;     cnt_nxt = cnt_r;         is_load_nxt = is_load_r;
    ld_idx_nxt = ld_idx_r;   ld_ir_nxt = ld_ir_r;     ld_or_nxt = ld_or_r;
    ld_cur_nxt = ld_cur_r;   x_nxt = x_r;             y_nxt = y_r;
    nx_nxt = nx_r;           ny_nxt = ny_r;           vx_nxt = vx_r;
    vy_nxt = vy_r;           d2b_nxt = d2b_r;         d2a_nxt = d2a_r;
    scan_cnt_nxt = scan_cnt_r; rd_idx_nxt = rd_idx_r; rd_vld_nxt = 1'b0;
    bef_nxt = bef_r;         aft_nxt = aft_r;         fnd_b_nxt = fnd_b_r;
    fnd_a_nxt = fnd_a_r;     cur_b_nxt = cur_b_r;     cur_a_nxt = cur_a_r;
    dv_nxt = dv_r;           sq_n_nxt = sq_n_r;       root_nxt = root_r;
    srem_nxt = srem_r;       drem_nxt = drem_r;       dq_nxt = dq_r;
    axis_nxt = axis_r;       out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en = 1'b0; rd_addr = '0; wr_in_en = 1'b0; wr_out_en = 1'b0;
    wr_addr = IdxW'(ld_idx_r);
    mul_a = '0; mul_b = '0;
    sq_op = '0;
    hit_b = 1'b0; hit_a = 1'b0;
    diff = {cur_a_r[31], cur_a_r} - {cur_b_r[31], cur_b_r};
    srem_sh = {srem_r, sq_n_r[63:62]};
    trial   = {1'b0, root_r, 2'b01};
    drem_sh = {drem_r, dq_r[32]};
    qbit    = drem_sh >= {2'b00, root_r};
    kp = axis_r ? ny_r : nx_r;
    kv = axis_r ? vy_r : vx_r;
    kick = (kp != 32'sd0 && !kp[31]) ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    ksum = {{3{kv[31]}}, kv} + {kick[33], kick};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          is_load_nxt = (in_data.action == rfps_pkg::ACT_LOAD);
          ld_idx_nxt = in_data.ring_index;
          ld_ir_nxt = in_data.ring_inner_radius;
          ld_or_nxt = in_data.ring_outer_radius;
          ld_cur_nxt = in_data.ring_current;
          x_nxt = in_data.particle_x;
          y_nxt = in_data.particle_y;
          vx_nxt = in_data.particle_vx;
          vy_nxt = in_data.particle_vy;
          nx_nxt = in_data.particle_x + in_data.particle_vx;
          ny_nxt = in_data.particle_y + in_data.particle_vy;
          state_nxt = (in_data.action == rfps_pkg::ACT_LOAD) ? S_LOAD : S_SQ;
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd0) begin
          mul_a = {1'b0, ld_ir_r}; mul_b = {2'b00, ld_ir_r};
        end else if (cnt_r == 6'd1) begin
          mul_a = {1'b0, ld_or_r}; mul_b = {2'b00, ld_or_r};
          wr_in_en = 32'(ld_idx_r) < NUM_RINGS;
        end else begin
          wr_out_en = 32'(ld_idx_r) < NUM_RINGS;
          state_nxt = S_DONE;
        end
      end
      S_SQ: begin
        case (cnt_r[2:0])
          3'd0:    sq_op = abs32(x_r);
          3'd1:    sq_op = abs32(y_r);
          3'd2:    sq_op = abs32(nx_r);
          3'd3:    sq_op = abs32(ny_r);
          default: sq_op = '0;
        endcase
        mul_a = sq_op; mul_b = {1'b0, sq_op};
        case (cnt_r[2:0])
          3'd1:    d2b_nxt = p_r;
          3'd2:    d2b_nxt = d2b_r + p_r;
          3'd3:    d2a_nxt = p_r;
          3'd4:    d2a_nxt = d2a_r + p_r;
          default: ;
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd4) begin
          state_nxt = S_SCAN;
          scan_cnt_nxt = '0;
          bef_nxt = NoRing; aft_nxt = NoRing;
          fnd_b_nxt = 1'b0; fnd_a_nxt = 1'b0;
          cur_b_nxt = '0;   cur_a_nxt = '0;
        end
      end
      S_SCAN: begin
        // entry is read in the cycle before its compare
        if (rd_vld_r) begin
          hit_b = (d2b_r > {2'b00, inner_rd_r}) && (d2b_r <= {2'b00, outer_rd_r});
          hit_a = (d2a_r > {2'b00, inner_rd_r}) && (d2a_r <= {2'b00, outer_rd_r});
          if (!fnd_b_r && hit_b) begin
            fnd_b_nxt = 1'b1; bef_nxt = rd_idx_r; cur_b_nxt = cur_rd_r;
          end
          if (!fnd_a_r && hit_a) begin
            fnd_a_nxt = 1'b1; aft_nxt = rd_idx_r; cur_a_nxt = cur_rd_r;
          end
        end
        if (scan_cnt_r < used_n) begin
          rd_en = 1'b1;
          rd_addr = IdxW'(scan_cnt_r);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_cnt_r;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = (bef_r != aft_r) ? S_DIFF : S_BOUNCE;
        end
      end
      S_DIFF: begin
        dv_nxt = diff[32] ? 33'(-diff) : 33'(diff);
        sq_n_nxt = d2a_r;
        root_nxt = '0;
        srem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // two bits of the radicand per step
        if (srem_sh >= trial) begin
          srem_nxt = 33'(srem_sh - trial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          srem_nxt = srem_sh[32:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        sq_n_nxt = {sq_n_r[61:0], 2'b00};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          cnt_nxt = '0;
          axis_nxt = 1'b0;
          state_nxt = (root_nxt == 32'd0) ? S_BOUNCE : S_KMUL;
        end
      end
      S_KMUL: begin
        mul_a = abs32(kp); mul_b = dv_r;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd1) begin
          // quotient is at most dv, so the top 31 bits start below the divisor
          drem_nxt = {2'b00, p_r[63:33]};
          dq_nxt = p_r[32:0];
          cnt_nxt = '0;
          state_nxt = S_KDIV;
        end
      end
      S_KDIV: begin
        drem_nxt = qbit ? 33'(drem_sh - {2'b00, root_r}) : drem_sh[32:0];
        dq_nxt = {dq_r[31:0], qbit};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd32) state_nxt = S_KADD;
      end
      S_KADD: begin
        if (axis_r) vy_nxt = sat35(ksum);
        else vx_nxt = sat35(ksum);
        cnt_nxt = '0;
        axis_nxt = 1'b1;
        state_nxt = axis_r ? S_BOUNCE : S_KMUL;
      end
      S_BOUNCE: begin
        vx_nxt = bounce(nx_r, vx_r, half_width_r);
        vy_nxt = bounce(ny_r, vy_r, half_height_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (is_load_r) begin
            out_data_nxt = '0;
          end else begin
            out_data_nxt.new_x = nx_r;
            out_data_nxt.new_y = ny_r;
            out_data_nxt.new_vx = vx_r;
            out_data_nxt.new_vy = vy_r;
            out_data_nxt.ring_changed = (bef_r != aft_r);
            out_data_nxt.ring_after = 4'(aft_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    p_nxt = {32'd0, mul_a} * {31'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      rd_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_load_r <= is_load_nxt;  ld_idx_r <= ld_idx_nxt;  ld_ir_r <= ld_ir_nxt;
    ld_or_r <= ld_or_nxt;      ld_cur_r <= ld_cur_nxt;  x_r <= x_nxt;
    y_r <= y_nxt;              nx_r <= nx_nxt;          ny_r <= ny_nxt;
    vx_r <= vx_nxt;            vy_r <= vy_nxt;          p_r <= p_nxt;
    d2b_r <= d2b_nxt;          d2a_r <= d2a_nxt;        scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r <= rd_idx_nxt;    bef_r <= bef_nxt;        aft_r <= aft_nxt;
    fnd_b_r <= fnd_b_nxt;      fnd_a_r <= fnd_a_nxt;    cur_b_r <= cur_b_nxt;
    cur_a_r <= cur_a_nxt;      dv_r <= dv_nxt;          sq_n_r <= sq_n_nxt;
    root_r <= root_nxt;        srem_r <= srem_nxt;      drem_r <= drem_nxt;
    dq_r <= dq_nxt;            axis_r <= axis_nxt;      out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/rfps_checker.sv =====
// Port-level checks for the ring flow particle step block, bound to its top level.
`default_nettype none
module rfps_checker #(
  parameter int NUM_RINGS = rfps_pkg::NumRingsDef
) (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire rfps_pkg::in_item_t  in_data,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire rfps_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted but block not busy next cycle");

  a_after_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ring_changed |-> 32'(out_data.ring_after) <= NUM_RINGS ||
    NUM_RINGS > 15)
    else $error("ring_after beyond table");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_data.action))
    else $error("accepted item has unknown action");

endmodule

bind ring_flow_particle_step rfps_checker #(.NUM_RINGS(NUM_RINGS)) u_rfps_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
